// File: design/mbr_pkg.sv
// Shared types, constants and helper functions of the Mandelbrot pixel block.
package mbr_pkg;

   localparam int PLANE_W     = 64;   // plane values are held as signed 64-bit fixed point
   localparam int WIDE_W      = 66;   // headroom for a three-term sum before saturation
   localparam int COORD_W     = 10;
   localparam int NUM_W       = 12;   // 3 * 1023 fits
   localparam int SIZE_W      = 11;
   localparam int ITER_W      = 16;
   localparam int GLYPH_W     = 7;
   localparam int GLYPH_Q_W   = 4;    // glyph index is below ten
   localparam int PROD10_W    = 20;   // iterations times ten
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_CAP = 2'd2;

   localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH   = 11'd80;
   localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT  = 11'd40;
   localparam logic [ITER_W-1:0] RST_ITERATION_CAP = 16'd100;

   localparam logic [GLYPH_W-1:0] GLYPH_AT_CAP = 7'h23;   // '#'

   typedef struct packed {
      logic accept;
      logic coord_step;
      logic load_c;
      logic mul;
      logic update;
      logic glyph_load;
      logic glyph_step;
      logic capture;
   } mbr_cmd_type;

   typedef struct packed {
      logic iter_at_cap;
      logic escape;
   } mbr_status_type;

   // Clamp a wide signed sum to the signed 64-bit range.
   function automatic logic signed [PLANE_W-1:0] sat_plane(input logic signed [WIDE_W-1:0] v);
      logic fits;
      fits = (&v[WIDE_W-1:PLANE_W-1]) || !(|v[WIDE_W-1:PLANE_W-1]);
      if (fits) begin
         return v[PLANE_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(PLANE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(PLANE_W-1){1'b1}}};
      end
   endfunction

   // Gradient " .:-=+*%@#"
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [GLYPH_Q_W-1:0] idx);
      logic [GLYPH_W-1:0] g;
      case (idx)
         4'd0: begin
            g = 7'h20;
         end
         4'd1: begin
            g = 7'h2E;
         end
         4'd2: begin
            g = 7'h3A;
         end
         4'd3: begin
            g = 7'h2D;
         end
         4'd4: begin
            g = 7'h3D;
         end
         4'd5: begin
            g = 7'h2B;
         end
         4'd6: begin
            g = 7'h2A;
         end
         4'd7: begin
            g = 7'h25;
         end
         4'd8: begin
            g = 7'h40;
         end
         default: begin
            g = GLYPH_AT_CAP;
         end
      endcase
      return g;
   endfunction

endpackage

// File: design/mbr_sdiv.sv
// Restoring divider datapath: one quotient bit per step, sequenced from outside.
module mbr_sdiv #(
   parameter int Q_W = 40,
   parameter int D_W = 10
) (
   input  logic           clock,
   input  logic           load,
   input  logic           step,
   input  logic [Q_W-1:0] dividend,
   input  logic [D_W-1:0] rem_init,
   input  logic [D_W-1:0] divisor,
   output logic [Q_W-1:0] quotient
);

   logic [Q_W-1:0] acc_ff, acc_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [D_W:0]   trial;
   logic [D_W:0]   diff;
   logic           fits;

   // Remainder stays below the divisor, so the top bit of diff is the borrow.
   assign trial = {rem_ff, acc_ff[Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[D_W];

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (load) begin
         acc_in = dividend;
         rem_in = rem_init;
         den_in = divisor;
      end else if (step) begin
         acc_in = {acc_ff[Q_W-2:0], fits};
         rem_in = fits ? diff[D_W-1:0] : trial[D_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = acc_ff;

endmodule

// File: design/mbr_datapath.sv
// Datapath: config registers, coordinate and glyph dividers, escape-time iteration.
module mbr_datapath import mbr_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int FRAC_BITS   = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mbr_cmd_type            cmd,
   output mbr_status_type         status,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [COORD_W-1:0]     req_column,
   input  logic [COORD_W-1:0]     req_row,
   output logic [GLYPH_W-1:0]     rsp_glyph,
   output logic [ITER_W-1:0]      rsp_iterations,
   output logic                   rsp_row_end
);

   localparam int QW      = NUM_W + FRAC_BITS;
   localparam int DXW     = $clog2(MAX_COLUMNS);
   localparam int DYW     = $clog2(MAX_ROWS);
   localparam int CLAMP_W = 13;
   localparam int M_W     = FRAC_BITS + 2;
   localparam int P_W     = 2 * M_W;
   localparam int SQ_W    = FRAC_BITS + 3;
   localparam int SUM_W   = SQ_W + 1;
   localparam int CR_W    = FRAC_BITS + 4;
   localparam int EXT_W   = 128;

   localparam logic signed [PLANE_W-1:0] TWO_FIX     = signed'(PLANE_W'(2) << FRAC_BITS);
   localparam logic signed [PLANE_W-1:0] NEG_TWO_FIX = -TWO_FIX;
   localparam logic signed [PLANE_W-1:0] ONE_FIX     = signed'(PLANE_W'(1) << FRAC_BITS);
   localparam logic [SUM_W-1:0]          FOUR_SUM    = SUM_W'(64'd4 << FRAC_BITS);
   localparam logic [PLANE_W-1:0]        PLANE_MAX   = {1'b0, {(PLANE_W-1){1'b1}}};
   localparam logic [CLAMP_W-1:0]        MAXC_M1     = CLAMP_W'(MAX_COLUMNS - 1);
   localparam logic [CLAMP_W-1:0]        MAXR_M1     = CLAMP_W'(MAX_ROWS - 1);

   // configuration
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [ITER_W-1:0] cap_ff, cap_in;

   // iteration state
   logic signed [PLANE_W-1:0] cr_ff, cr_in;
   logic signed [PLANE_W-1:0] ci_ff, ci_in;
   logic signed [PLANE_W-1:0] zr_ff, zr_in;
   logic signed [PLANE_W-1:0] zi_ff, zi_in;
   logic [SQ_W-1:0]           sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]           sq_i_ff, sq_i_in;
   logic signed [CR_W-1:0]    cross_ff, cross_in;
   logic                      big_ff, big_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic                      row_end_ff, row_end_in;

   // result registers
   logic [GLYPH_W-1:0] glyph_out_ff, glyph_out_in;
   logic [ITER_W-1:0]  iters_out_ff, iters_out_in;
   logic               row_end_out_ff, row_end_out_in;

   logic [CLAMP_W-1:0] dx_raw, dx_lim, dy_raw, dy_lim;
   logic [NUM_W-1:0]   num_x, num_y;
   logic [QW-1:0]      quo_x, quo_y;
   logic [PROD10_W-1:0] prod10;
   logic [GLYPH_Q_W-1:0] quo_g;
   logic [EXT_W-1:0]   qx_ext, qy_ext;
   logic [PLANE_W-1:0] vx, vy;

   logic              big;
   logic [M_W-1:0]    mag_r, mag_i;
   logic [P_W-1:0]    prod_rr, prod_ii, prod_ri;
   logic [SQ_W-1:0]   mag_x;
   logic signed [CR_W-1:0] cross_pos;
   logic [SUM_W-1:0]  sq_sum;
   logic signed [WIDE_W-1:0] zr_sum, dbl, zi_sum;
   logic signed [PLANE_W-1:0] zi_mid;
   logic              at_cap;

   // ---------------- configuration ----------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      cap_in    = cap_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[SIZE_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[SIZE_W-1:0];
            end
            CSR_ITERATION_CAP: begin
               cap_in = csr_wdata[ITER_W-1:0];
            end
            default: begin
               cap_in = cap_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         cap_ff    <= RST_ITERATION_CAP;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         cap_ff    <= cap_in;
      end
   end

   // ---------------- coordinate mapping ----------------
   // Divisor is size - 1, held between 1 and the maximum size - 1.
   assign dx_raw = (width_ff < SIZE_W'(2)) ? CLAMP_W'(1) : CLAMP_W'(width_ff - SIZE_W'(1));
   assign dx_lim = (dx_raw > MAXC_M1) ? MAXC_M1 : dx_raw;
   assign dy_raw = (height_ff < SIZE_W'(2)) ? CLAMP_W'(1) : CLAMP_W'(height_ff - SIZE_W'(1));
   assign dy_lim = (dy_raw > MAXR_M1) ? MAXR_M1 : dy_raw;

   assign num_x = (NUM_W'(req_column) << 1) + NUM_W'(req_column);
   assign num_y = NUM_W'(req_row) << 1;

   mbr_sdiv #(.Q_W(QW), .D_W(DXW)) u_div_x (
      .clock    (clock),
      .load     (cmd.accept),
      .step     (cmd.coord_step),
      .dividend ({num_x, {FRAC_BITS{1'b0}}}),
      .rem_init ('0),
      .divisor  (DXW'(dx_lim)),
      .quotient (quo_x)
   );

   mbr_sdiv #(.Q_W(QW), .D_W(DYW)) u_div_y (
      .clock    (clock),
      .load     (cmd.accept),
      .step     (cmd.coord_step),
      .dividend ({num_y, {FRAC_BITS{1'b0}}}),
      .rem_init ('0),
      .divisor  (DYW'(dy_lim)),
      .quotient (quo_y)
   );

   // Quotient at or above 2^63 saturates to the largest plane value.
   assign qx_ext = EXT_W'(quo_x);
   assign qy_ext = EXT_W'(quo_y);
   assign vx = (|qx_ext[EXT_W-1:PLANE_W-1]) ? PLANE_MAX : qx_ext[PLANE_W-1:0];
   assign vy = (|qy_ext[EXT_W-1:PLANE_W-1]) ? PLANE_MAX : qy_ext[PLANE_W-1:0];

   // ---------------- iteration, first half: squares and cross term ----------------
   // Beyond magnitude two the squares alone exceed four, so only products of operands
   // up to two are ever used.
   assign big = (zr_ff > TWO_FIX) || (zr_ff < NEG_TWO_FIX) ||
                (zi_ff > TWO_FIX) || (zi_ff < NEG_TWO_FIX);
   assign mag_r = zr_ff[PLANE_W-1] ? (~zr_ff[M_W-1:0] + M_W'(1)) : zr_ff[M_W-1:0];
   assign mag_i = zi_ff[PLANE_W-1] ? (~zi_ff[M_W-1:0] + M_W'(1)) : zi_ff[M_W-1:0];
   assign prod_rr = P_W'(mag_r) * P_W'(mag_r);
   assign prod_ii = P_W'(mag_i) * P_W'(mag_i);
   assign prod_ri = P_W'(mag_r) * P_W'(mag_i);
   assign mag_x = prod_ri[FRAC_BITS +: SQ_W];
   assign cross_pos = signed'({1'b0, mag_x});

   // ---------------- iteration, second half: escape test and update ----------------
   assign sq_sum = {1'b0, sq_r_ff} + {1'b0, sq_i_ff};
   assign zr_sum = WIDE_W'(signed'({1'b0, sq_r_ff})) - WIDE_W'(signed'({1'b0, sq_i_ff}))
                   + WIDE_W'(cr_ff);
   assign dbl    = WIDE_W'(cross_ff) <<< 1;
   assign zi_mid = sat_plane(dbl);
   assign zi_sum = WIDE_W'(zi_mid) + WIDE_W'(ci_ff);

   assign at_cap = (iter_ff == cap_ff);
   assign status.iter_at_cap = at_cap;
   assign status.escape      = big_ff || (sq_sum > FOUR_SUM);

   // ---------------- glyph index ----------------
   assign prod10 = (PROD10_W'(iter_ff) << 3) + (PROD10_W'(iter_ff) << 1);

   // Upper bits of iter*10 stay below the cap since iter < cap here.
   mbr_sdiv #(.Q_W(GLYPH_Q_W), .D_W(ITER_W)) u_div_g (
      .clock    (clock),
      .load     (cmd.glyph_load),
      .step     (cmd.glyph_step),
      .dividend (prod10[GLYPH_Q_W-1:0]),
      .rem_init (prod10[PROD10_W-1:GLYPH_Q_W]),
      .divisor  (cap_ff),
      .quotient (quo_g)
   );

   // ---------------- next-state logic ----------------
   always_comb begin
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      sq_r_in        = sq_r_ff;
      sq_i_in        = sq_i_ff;
      cross_in       = cross_ff;
      big_in         = big_ff;
      iter_in        = iter_ff;
      row_end_in     = row_end_ff;
      glyph_out_in   = glyph_out_ff;
      iters_out_in   = iters_out_ff;
      row_end_out_in = row_end_out_ff;

      if (cmd.accept) begin
         row_end_in = (SIZE_W'(req_column) == (width_ff - SIZE_W'(1)));
      end
      if (cmd.load_c) begin
         cr_in   = signed'(vx) - TWO_FIX;
         ci_in   = signed'(vy) - ONE_FIX;
         zr_in   = '0;
         zi_in   = '0;
         iter_in = '0;
      end
      if (cmd.mul) begin
         big_in   = big;
         sq_r_in  = prod_rr[FRAC_BITS +: SQ_W];
         sq_i_in  = prod_ii[FRAC_BITS +: SQ_W];
         cross_in = (zr_ff[PLANE_W-1] ^ zi_ff[PLANE_W-1]) ? -cross_pos : cross_pos;
      end
      if (cmd.update) begin
         zr_in   = sat_plane(zr_sum);
         zi_in   = sat_plane(zi_sum);
         iter_in = iter_ff + ITER_W'(1);
      end
      if (cmd.capture) begin
         glyph_out_in   = at_cap ? GLYPH_AT_CAP : glyph_of(quo_g);
         iters_out_in   = iter_ff;
         row_end_out_in = row_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff          <= cr_in;
      ci_ff          <= ci_in;
      zr_ff          <= zr_in;
      zi_ff          <= zi_in;
      sq_r_ff        <= sq_r_in;
      sq_i_ff        <= sq_i_in;
      cross_ff       <= cross_in;
      big_ff         <= big_in;
      iter_ff        <= iter_in;
      row_end_ff     <= row_end_in;
      glyph_out_ff   <= glyph_out_in;
      iters_out_ff   <= iters_out_in;
      row_end_out_ff <= row_end_out_in;
   end

   assign rsp_glyph      = glyph_out_ff;
   assign rsp_iterations = iters_out_ff;
   assign rsp_row_end    = row_end_out_ff;

endmodule

// File: design/mbr_ctrl.sv
// Controller: sequences coordinate division, iteration, glyph division and the result strobe.
module mbr_ctrl import mbr_pkg::*; #(
   parameter int COORD_STEPS = 40
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   output mbr_cmd_type    cmd,
   input  mbr_status_type status
);

   localparam int CNT_W = $clog2(COORD_STEPS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COORD = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_ADD   = 3'd4;
   localparam logic [2:0] S_GLOAD = 3'd5;
   localparam logic [2:0] S_GDIV  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               cnt_in     = CNT_W'(COORD_STEPS - 1);
               state_in   = S_COORD;
            end
         end
         S_COORD: begin
            cmd.coord_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_LOAD;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_LOAD: begin
            cmd.load_c = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            if (status.iter_at_cap) begin
               state_in = S_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (status.escape) begin
               state_in = S_GLOAD;
            end else begin
               cmd.update = 1'b1;
               state_in   = S_MUL;
            end
         end
         S_GLOAD: begin
            cmd.glyph_load = 1'b1;
            cnt_in         = CNT_W'(GLYPH_Q_W - 1);
            state_in       = S_GDIV;
         end
         S_GDIV: begin
            cmd.glyph_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_DONE: begin
            cmd.capture = 1'b1;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// File: design/mandelbrot_ascii_pixel.sv
// Top level of the Mandelbrot escape-time ASCII pixel block.
// One pixel is in flight at a time: a request is taken when start is high and busy is low,
// and the result appears on the rsp_ ports for exactly one cycle with rsp_valid high;
// there is no stall on the result side, so capture it in that cycle. The time that
// busy lasts is set by the restoring coordinate dividers, which produce one of
// 12 + FRAC_BITS quotient bits per cycle, by the escape loop, which runs a multiply step
// and an add-and-test step on each iteration, and, when the point escapes rather than
// reaching the iteration cap, by a four-step glyph division. busy drops in the cycle
// the result is shown, so the next request may be given then. Configuration writes take
// effect at once and belong to idle periods.
module mandelbrot_ascii_pixel import mbr_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   parameter int MAX_ROWS    = 1024,
   parameter int FRAC_BITS   = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_W-1:0]     req_column,
   input  logic [COORD_W-1:0]     req_row,
   output logic                   rsp_valid,
   output logic [GLYPH_W-1:0]     rsp_glyph,
   output logic [ITER_W-1:0]      rsp_iterations,
   output logic                   rsp_row_end,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COORD_STEPS = NUM_W + FRAC_BITS;

   mbr_cmd_type    cmd;
   mbr_status_type status;

   mbr_ctrl #(.COORD_STEPS(COORD_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   mbr_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_glyph      (rsp_glyph),
      .rsp_iterations (rsp_iterations),
      .rsp_row_end    (rsp_row_end)
   );

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not make the block busy");

   // A result is never shown while a pixel is still being worked on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Work only ends by delivering a result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule
